[design/dfs_pkg.sv]
// Shared types and constants for the debug frame serializer.
package dfs_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int IDX_W        = 3;
    localparam int SAMPLE_W     = 16;
    localparam int BYTE_W       = 8;
    localparam int SUM_W        = 16;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SEND  = 1'b1;

    localparam logic [SUM_W-1:0]  SUM_SEED   = 16'h0067;
    localparam logic [BYTE_W-1:0] SUM_MASK   = 8'h3D;
    localparam logic [BYTE_W-1:0] HEAD_FIRST = 8'h3C;
    localparam logic [BYTE_W-1:0] HEAD_NEXT  = 8'hDD;
    localparam logic [BYTE_W-1:0] TAIL_FIRST = 8'h88;
    localparam logic [BYTE_W-1:0] TAIL_NEXT  = 8'h99;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD0,
        ST_HEAD1,
        ST_COUNT,
        ST_DATA,
        ST_SUM_HI,
        ST_SUM_LO,
        ST_TAIL0,
        ST_TAIL1
    } state_t;

    typedef struct packed {
        logic              clear;
        logic              add;
        logic [BYTE_W-1:0] data;
    } sum_ctrl_t;

endpackage

[design/dfs_store.sv]
// Channel value store, cleared at reset, one write and one read port.
module dfs_store #(
    parameter int CHANNELS = dfs_pkg::CHANNELS_DEF,
    parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [dfs_pkg::IDX_W-1:0]     wr_index,
    input  logic [dfs_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic [CH_W-1:0]               rd_index,
    output logic [dfs_pkg::SAMPLE_W-1:0]  rd_data
);

    logic [dfs_pkg::SAMPLE_W-1:0] store_reg [CHANNELS];

    // Writes beyond the store match no entry and are dropped.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            if (!aresetn) begin
                store_reg[i] <= '0;
            end else if (wr_en && (32'(wr_index) == i)) begin
                store_reg[i] <= wr_data;
            end
        end
    end

    assign rd_data = store_reg[rd_index];

endmodule

[design/dfs_checksum.sv]
// Checksum accumulator: adds one masked byte per step.
module dfs_checksum (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dfs_pkg::sum_ctrl_t         ctrl,
    output logic [dfs_pkg::SUM_W-1:0]  sum
);

    logic [dfs_pkg::SUM_W-1:0] sum_reg;
    logic [dfs_pkg::SUM_W-1:0] sum_next;

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.clear) begin
            sum_next = dfs_pkg::SUM_SEED;
        end else if (ctrl.add) begin
            sum_next = sum_reg
                     + dfs_pkg::SUM_W'(ctrl.data ^ dfs_pkg::SUM_MASK);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= dfs_pkg::SUM_SEED;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

[design/dfs_seq.sv]
// Frame sequencer: walks the frame one byte per step into the output register.
module dfs_seq #(
    parameter int CHANNELS = dfs_pkg::CHANNELS_DEF,
    parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    output logic                          idle,
    output logic [CH_W-1:0]               rd_index,
    input  logic [dfs_pkg::SAMPLE_W-1:0]  rd_data,
    input  logic [dfs_pkg::SUM_W-1:0]     sum,
    output dfs_pkg::sum_ctrl_t            sum_ctrl,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dfs_pkg::BYTE_W-1:0]    m_byte,
    output logic                          m_last
);

    dfs_pkg::state_t state_reg, state_next;

    logic [CH_W-1:0]             ch_reg, ch_next;
    logic                        half_reg, half_next;
    logic                        m_valid_reg, m_valid_next;
    logic [dfs_pkg::BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic                        m_last_reg, m_last_next;
    logic                        load;
    logic                        data_done;
    logic [dfs_pkg::BYTE_W-1:0]  data_byte;

    // Output register takes a new byte when empty or being drained.
    assign load      = !m_valid_reg || m_ready;
    assign data_done = (ch_reg == CH_W'(CHANNELS - 1)) && half_reg;
    assign data_byte = half_reg ? rd_data[7:0] : rd_data[15:8];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dfs_pkg::ST_IDLE:   if (start) state_next = dfs_pkg::ST_HEAD0;
            dfs_pkg::ST_HEAD0:  if (load) state_next = dfs_pkg::ST_HEAD1;
            dfs_pkg::ST_HEAD1:  if (load) state_next = dfs_pkg::ST_COUNT;
            dfs_pkg::ST_COUNT:  if (load) state_next = dfs_pkg::ST_DATA;
            dfs_pkg::ST_DATA:   if (load && data_done) state_next = dfs_pkg::ST_SUM_HI;
            dfs_pkg::ST_SUM_HI: if (load) state_next = dfs_pkg::ST_SUM_LO;
            dfs_pkg::ST_SUM_LO: if (load) state_next = dfs_pkg::ST_TAIL0;
            dfs_pkg::ST_TAIL0:  if (load) state_next = dfs_pkg::ST_TAIL1;
            dfs_pkg::ST_TAIL1:  if (load) state_next = dfs_pkg::ST_IDLE;
            default:            state_next = dfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ch_next        = ch_reg;
        half_next      = half_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;
        sum_ctrl.clear = 1'b0;
        sum_ctrl.add   = 1'b0;
        sum_ctrl.data  = data_byte;
        unique case (state_reg)
            dfs_pkg::ST_IDLE: begin
                ch_next        = '0;
                half_next      = 1'b0;
                sum_ctrl.clear = start;
            end
            dfs_pkg::ST_HEAD0: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = dfs_pkg::HEAD_FIRST;
                    m_last_next  = 1'b0;
                end
            end
            dfs_pkg::ST_HEAD1: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = dfs_pkg::HEAD_NEXT;
                    m_last_next  = 1'b0;
                end
            end
            dfs_pkg::ST_COUNT: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = dfs_pkg::BYTE_W'(CHANNELS);
                    m_last_next  = 1'b0;
                end
            end
            dfs_pkg::ST_DATA: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = data_byte;
                    m_last_next  = 1'b0;
                    sum_ctrl.add = 1'b1;
                    half_next    = !half_reg;
                    if (half_reg && !data_done) begin
                        ch_next = ch_reg + CH_W'(1);
                    end
                end
            end
            dfs_pkg::ST_SUM_HI: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = sum[15:8];
                    m_last_next  = 1'b0;
                end
            end
            dfs_pkg::ST_SUM_LO: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = sum[7:0];
                    m_last_next  = 1'b0;
                end
            end
            dfs_pkg::ST_TAIL0: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = dfs_pkg::TAIL_FIRST;
                    m_last_next  = 1'b0;
                end
            end
            dfs_pkg::ST_TAIL1: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = dfs_pkg::TAIL_NEXT;
                    m_last_next  = 1'b1;
                end
            end
            default: begin
                ch_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dfs_pkg::ST_IDLE;
            ch_reg      <= '0;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            half_reg    <= half_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign idle     = (state_reg == dfs_pkg::ST_IDLE);
    assign rd_index = ch_reg;
    assign m_valid  = m_valid_reg;
    assign m_byte   = m_byte_reg;
    assign m_last   = m_last_reg;

endmodule

[design/debug_frame_serializer_unit.sv]
// Top level of the debug frame serializer.
//
// Input channel (s_): one request per item. mode 0 stores s_sample_value in
// the channel slot s_channel_index (slots at or beyond CHANNELS are dropped)
// and produces no output. mode 1 sends one frame of 2*CHANNELS+7 bytes:
// 3C DD, channel count, each channel high then low byte, 16-bit checksum
// high byte first, then 88 99 with m_frame_last set on the final byte.
// Output channel (m_): one byte per request, from an output register.
// A send request holds s_ready low while the sequencer walks the frame, one
// byte per cycle while the receiver keeps m_ready high, adding each channel
// data byte into the checksum adder. The sequencer enters ST_HEAD0 the cycle
// after the send is accepted and loads the first byte into the output
// register from there once the register is free. The
// next request is taken as soon as the last byte is loaded, while it still
// waits in the output register. When the receiver stalls, the sequencer
// holds its position and the output register holds its byte. Reset clears
// the channel store to zero, empties the output register and returns the
// sequencer to idle.
module debug_frame_serializer_unit #(
    parameter int CHANNELS = dfs_pkg::CHANNELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [dfs_pkg::IDX_W-1:0]     s_channel_index,
    input  logic signed [dfs_pkg::SAMPLE_W-1:0] s_sample_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dfs_pkg::BYTE_W-1:0]    m_frame_byte,
    output logic                          m_frame_last
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                         accept;
    logic                         wr_en;
    logic                         start;
    logic                         idle;
    logic [CH_W-1:0]              rd_index;
    logic [dfs_pkg::SAMPLE_W-1:0] rd_data;
    logic [dfs_pkg::SUM_W-1:0]    sum;
    dfs_pkg::sum_ctrl_t           sum_ctrl;

    assign s_ready = idle;
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (s_mode == dfs_pkg::MODE_WRITE);
    assign start   = accept && (s_mode == dfs_pkg::MODE_SEND);

    dfs_store #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_index (s_channel_index),
        .wr_data  (s_sample_value),
        .rd_index (rd_index),
        .rd_data  (rd_data)
    );

    dfs_checksum u_checksum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sum_ctrl),
        .sum     (sum)
    );

    dfs_seq #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .idle     (idle),
        .rd_index (rd_index),
        .rd_data  (rd_data),
        .sum      (sum),
        .sum_ctrl (sum_ctrl),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_byte   (m_frame_byte),
        .m_last   (m_frame_last)
    );

endmodule

[sim/tb_debug_frame_serializer_unit.sv]
// Testbench for debug_frame_serializer_unit: channel writes and frame sends checked byte by byte.
`timescale 1ns / 1ps

module tb_debug_frame_serializer_unit;

    localparam int CHANNELS    = dfs_pkg::CHANNELS_DEF;
    localparam int FRAME_LEN   = 2 * CHANNELS + 7;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [dfs_pkg::BYTE_W-1:0] data;
        logic                       last;
    } frame_beat_t;

    logic                           aclk            = 1'b0;
    logic                           aresetn         = 1'b0;
    logic                           s_valid         = 1'b0;
    logic                           s_ready;
    logic                           s_mode          = dfs_pkg::MODE_WRITE;
    logic [dfs_pkg::IDX_W-1:0]      s_channel_index = '0;
    logic [dfs_pkg::SAMPLE_W-1:0]   s_sample_value  = '0;
    logic                           m_valid;
    logic                           m_ready         = 1'b0;
    logic [dfs_pkg::BYTE_W-1:0]     m_frame_byte;
    logic                           m_frame_last;

    // Shadow of the channel store and the bytes still owed by the block
    logic [dfs_pkg::SAMPLE_W-1:0]   chan_vals [CHANNELS];
    frame_beat_t                    frame_due [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int writes_done    = 0;
    int sends_done     = 0;
    int bytes_checked  = 0;

    debug_frame_serializer_unit #(
        .CHANNELS(CHANNELS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_channel_index (s_channel_index),
        .s_sample_value  (s_sample_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_frame_last    (m_frame_last)
    );

    always #4 aclk = ~aclk;

    initial begin
        for (int k = 0; k < CHANNELS; k++) begin
            chan_vals[k] = '0;
        end
    end

    function automatic void due_push(logic [dfs_pkg::BYTE_W-1:0] d, logic l);
        frame_beat_t beat;
        beat.data = d;
        beat.last = l;
        frame_due.push_back(beat);
    endfunction

    // Update the shadow store, or queue the full frame a send produces
    function automatic void frame_model_apply(logic mode, logic [dfs_pkg::IDX_W-1:0] idx,
                                              logic [dfs_pkg::SAMPLE_W-1:0] val);
        logic [dfs_pkg::SUM_W-1:0]  csum;
        logic [dfs_pkg::BYTE_W-1:0] hi;
        logic [dfs_pkg::BYTE_W-1:0] lo;
        if (mode == dfs_pkg::MODE_WRITE) begin
            writes_done++;
            // drop writes to slots past the store
            if (int'(idx) < CHANNELS) begin
                chan_vals[idx] = val;
            end
        end else begin
            sends_done++;
            due_push(dfs_pkg::HEAD_FIRST, 1'b0);
            due_push(dfs_pkg::HEAD_NEXT, 1'b0);
            due_push(dfs_pkg::BYTE_W'(CHANNELS), 1'b0);
            csum = dfs_pkg::SUM_SEED;
            for (int k = 0; k < CHANNELS; k++) begin
                hi = chan_vals[k][15:8];
                lo = chan_vals[k][7:0];
                due_push(hi, 1'b0);
                due_push(lo, 1'b0);
                csum = csum + {8'h00, hi ^ dfs_pkg::SUM_MASK};
                csum = csum + {8'h00, lo ^ dfs_pkg::SUM_MASK};
            end
            due_push(csum[15:8], 1'b0);
            due_push(csum[7:0], 1'b0);
            due_push(dfs_pkg::TAIL_FIRST, 1'b0);
            due_push(dfs_pkg::TAIL_NEXT, 1'b1);
        end
    endfunction

    // Called and returns at a falling edge; hold the request until accepted
    task automatic send_item(logic mode, logic [dfs_pkg::IDX_W-1:0] idx,
                             logic [dfs_pkg::SAMPLE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_channel_index <= idx;
        s_sample_value  <= val;
        do @(posedge aclk); while (!s_ready);
        frame_model_apply(mode, idx, val);
        @(negedge aclk);
    endtask

    task automatic wait_frames_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (frame_due.size() != 0);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : byte_checker
        frame_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_due.size() == 0) begin
                err_count++;
                $display("%0t: unexpected byte %02h last %0b", $time, m_frame_byte,
                         m_frame_last);
            end else begin
                want = frame_due.pop_front();
                bytes_checked++;
                if (m_frame_byte !== want.data) begin
                    err_count++;
                    $display("%0t: frame_byte expected %02h actual %02h", $time, want.data,
                             m_frame_byte);
                end
                if (m_frame_last !== want.last) begin
                    err_count++;
                    $display("%0t: frame_last expected %0b actual %0b", $time, want.last,
                             m_frame_last);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // A send right after reset must carry an all-zero store
    task automatic test_cleared_store();
        send_item(dfs_pkg::MODE_SEND, '0, '0);
    endtask

    task automatic test_value_extremes();
        send_item(dfs_pkg::MODE_WRITE, 3'd0, 16'h8000);
        send_item(dfs_pkg::MODE_WRITE, 3'd7, 16'h7FFF);
        send_item(dfs_pkg::MODE_WRITE, 3'd3, 16'hFFFF);
        send_item(dfs_pkg::MODE_WRITE, 3'd1, 16'h5555);
        send_item(dfs_pkg::MODE_WRITE, 3'd2, 16'hAAAA);
        send_item(dfs_pkg::MODE_WRITE, 3'd4, 16'h0001);
        send_item(dfs_pkg::MODE_WRITE, 3'd5, 16'hFF00);
        send_item(dfs_pkg::MODE_WRITE, 3'd6, 16'h00FF);
        send_item(dfs_pkg::MODE_SEND, '0, '0);
        // overwrite a slot and see the new value go out
        send_item(dfs_pkg::MODE_WRITE, 3'd0, 16'h0000);
        send_item(dfs_pkg::MODE_WRITE, 3'd3, 16'h1234);
        send_item(dfs_pkg::MODE_SEND, '0, '0);
    endtask

    // Index and value on a send must not touch the store; frames back to back
    task automatic test_send_ignores_fields();
        send_item(dfs_pkg::MODE_SEND, 3'd7, 16'hFFFF);
        send_item(dfs_pkg::MODE_SEND, 3'd5, 16'h8001);
        send_item(dfs_pkg::MODE_SEND, 3'd0, 16'h7FFE);
    endtask

    task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
        logic mode;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) begin
            mode = ($urandom_range(99) < 25) ? dfs_pkg::MODE_SEND : dfs_pkg::MODE_WRITE;
            send_item(mode, dfs_pkg::IDX_W'($urandom_range(CHANNELS - 1)),
                      dfs_pkg::SAMPLE_W'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_cleared_store();
        test_value_extremes();
        test_send_ignores_fields();

        test_random_traffic(45, 0, 0);
        test_random_traffic(45, 55, 0);
        wait_frames_drained();
        test_random_traffic(45, 0, 55);
        test_random_traffic(45, 8, 8);

        wait_frames_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // catch any stray bytes after the last frame
        repeat (2 * FRAME_LEN) @(negedge aclk);

        $display("Covered %0d channel writes and %0d frame sends, %0d bytes checked,",
                 writes_done, sends_done, bytes_checked);
        $display("with sender gaps and receiver stalls in separate and mixed phases.");
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
